[rtl/csem_pkg.sv]
// shared widths, codes and types of the counting semaphore with wait list
package csem_pkg;

	localparam int ID_W      = 31;
	localparam int CNT_W     = 16;
	localparam int REQ_W     = 2;
	localparam int STAT_W    = 3;
	localparam int MAX_WAITERS = 16;
	localparam int SLOTS     = 16;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int TOTAL_W   = SLOT_W + 1;
	localparam int WAIT_CAP  = (MAX_WAITERS < SLOTS) ? MAX_WAITERS : SLOTS;

	// request codes
	localparam logic [REQ_W-1:0] REQ_TRY  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WAIT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_INC  = 2'd2;

	typedef enum logic [STAT_W-1:0] {
		ST_GRANTED      = 3'd0,
		ST_REFUSED      = 3'd1,
		ST_ENQUEUED     = 3'd2,
		ST_NOT_ENQUEUED = 3'd3,
		ST_INCREMENTED  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EMIT,
		S_SCAN,
		S_DRAIN
	} state_t;

endpackage

[rtl/csem_ifs.sv]
// request, result and configuration channel interfaces
interface csem_req_if;
	import csem_pkg::*;
	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [ID_W-1:0]     requester_id;
	modport source (output valid, req_type, requester_id, input ready);
	modport sink   (input valid, req_type, requester_id, output ready);
endinterface

interface csem_res_if;
	import csem_pkg::*;
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic                woken_valid;
	logic [ID_W-1:0]     woken_id;
	logic [CNT_W-1:0]    count_after;
	logic                last;
	modport source (output valid, status, woken_valid, woken_id, count_after, last,
		input ready);
	modport sink   (input valid, status, woken_valid, woken_id, count_after, last,
		output ready);
endinterface

interface csem_cfg_if;
	import csem_pkg::*;
	logic                valid;
	logic                ready;
	logic [CNT_W-1:0]    initial_count;
	modport source (output valid, initial_count, input ready);
	modport sink   (input valid, initial_count, output ready);
endinterface

[rtl/csem_ram.sv]
// generic single write port ram with registered read
module csem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/counting_semaphore_wait_queue.sv]
// counting semaphore with a fifo wait list, one shared compare unit scanning the list
// try, wait with a free unit or a full list, unknown, increment on an empty list: result goes
// via the emit state to the free output register; wait with no unit: one list entry a cycle
// increment with n waiters: one woken item per read through the list ram read port
// the next item is taken once the last result has been loaded into the output register
// arst_n clears the count, the list total, the sequencer and the output valid
module counting_semaphore_wait_queue (
	input logic   clk,
	input logic   arst_n,
	csem_req_if.sink   req,
	csem_res_if.source res,
	csem_cfg_if.sink   cfg
);
	import csem_pkg::*;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [TOTAL_W-1:0]   total_q, total_d;
	logic [TOTAL_W-1:0]   idx_q, idx_d;
	logic                 rd_vld_q, rd_vld_d;
	status_t              pend_q, pend_d;
	logic [ID_W-1:0]      id_q;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic                 out_wvalid_q;
	logic [ID_W-1:0]      out_wid_q;
	logic [CNT_W-1:0]     out_count_q;
	logic                 out_last_q;

	logic                 req_fire, cfg_fire, out_free, load_out;
	status_t              o_status;
	logic                 o_wvalid, o_last;
	logic [ID_W-1:0]      o_wid;
	logic                 ram_we;
	logic [ID_W-1:0]      ram_rdata;
	logic                 drain_last;

	// handshakes
	assign cfg.ready = (state_q == S_IDLE);
	assign req.ready = (state_q == S_IDLE) && !cfg.valid;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign drain_last = ((idx_q + TOTAL_W'(1)) == total_q);

	// wait list storage
	csem_ram #(
		.WIDTH(ID_W),
		.DEPTH(SLOTS)
	) u_list (
		.clk  (clk),
		.we   (ram_we),
		.waddr(total_q[SLOT_W-1:0]),
		.wdata(id_q),
		.raddr(idx_q[SLOT_W-1:0]),
		.rdata(ram_rdata)
	);

	// sequencer next state and datapath controls
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		total_d  = total_q;
		idx_d    = idx_q;
		rd_vld_d = rd_vld_q;
		pend_d   = pend_q;
		load_out = 1'b0;
		o_status = pend_q;
		o_wvalid = 1'b0;
		o_wid    = '0;
		o_last   = 1'b1;
		ram_we   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cfg_fire) begin
					count_d = cfg.initial_count;
					total_d = '0;
				end else if (req_fire) begin
					idx_d    = '0;
					rd_vld_d = 1'b0;
					case (req.req_type)
						REQ_TRY, REQ_WAIT: begin
							if (count_q != '0) begin
								count_d = count_q - CNT_W'(1);
								pend_d  = ST_GRANTED;
								state_d = S_EMIT;
							end else if (req.req_type == REQ_TRY) begin
								pend_d  = ST_REFUSED;
								state_d = S_EMIT;
							end else if (total_q >= TOTAL_W'(WAIT_CAP)) begin
								pend_d  = ST_NOT_ENQUEUED;
								state_d = S_EMIT;
							end else begin
								state_d = S_SCAN;
							end
						end
						REQ_INC: begin
							if (count_q != '1) begin
								count_d = count_q + CNT_W'(1);
							end
							pend_d = ST_INCREMENTED;
							if (total_q == '0) begin
								state_d = S_EMIT;
							end else begin
								state_d = S_DRAIN;
							end
						end
						default: begin
							pend_d  = ST_REFUSED;
							state_d = S_EMIT;
						end
					endcase
				end
			end
			S_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SCAN: begin
				// compare the entry read last cycle, issue the next read
				if (rd_vld_q && (ram_rdata == id_q)) begin
					pend_d  = ST_NOT_ENQUEUED;
					state_d = S_EMIT;
				end else if (idx_q == total_q) begin
					ram_we  = 1'b1;
					total_d = total_q + TOTAL_W'(1);
					pend_d  = ST_ENQUEUED;
					state_d = S_EMIT;
				end else begin
					idx_d    = idx_q + TOTAL_W'(1);
					rd_vld_d = 1'b1;
				end
			end
			S_DRAIN: begin
				// one waiter per read, oldest first
				if (!rd_vld_q) begin
					rd_vld_d = 1'b1;
				end else if (out_free) begin
					load_out = 1'b1;
					o_status = ST_INCREMENTED;
					o_wvalid = 1'b1;
					o_wid    = ram_rdata;
					o_last   = drain_last;
					idx_d    = idx_q + TOTAL_W'(1);
					rd_vld_d = 1'b0;
					if (drain_last) begin
						total_d = '0;
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			total_q  <= '0;
			idx_q    <= '0;
			rd_vld_q <= 1'b0;
			pend_q   <= ST_GRANTED;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			total_q  <= total_d;
			idx_q    <= idx_d;
			rd_vld_q <= rd_vld_d;
			pend_q   <= pend_d;
		end
	end

	// requester id of the item in work
	always_ff @(posedge clk) begin
		if (req_fire) begin
			id_q <= req.requester_id;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= o_status;
			out_wvalid_q <= o_wvalid;
			out_wid_q    <= o_wid;
			out_count_q  <= count_q;
			out_last_q   <= o_last;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.status      = out_status_q;
	assign res.woken_valid = out_wvalid_q;
	assign res.woken_id    = out_wid_q;
	assign res.count_after = out_count_q;
	assign res.last        = out_last_q;

endmodule

[tb/counting_semaphore_wait_queue_tb.sv]
// testbench for the counting semaphore with fifo wait list: predicted results, random traffic
module counting_semaphore_wait_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csem_pkg::*;

	// one result of the block, as seen on the result channel
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              woken_valid;
		logic [ID_W-1:0]   woken_id;
		logic [CNT_W-1:0]  count_after;
		logic              last;
	} sem_result_t;

	// reserved request code, answered as refused
	localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

	class semaphore_scoreboard;
		bit [CNT_W-1:0] units;
		bit [ID_W-1:0]  waiters[$];
		sem_result_t    pending[$];
		int             mismatches;
		int             kind_seen[4];
		int             results_seen;
		int             woken_seen;
		int             list_refusals;
		int             count_loads;

		// a count load also empties the wait list
		function void load_count(bit [CNT_W-1:0] value);
			units = value;
			waiters.delete();
			count_loads++;
		endfunction

		function void push_result(bit [STAT_W-1:0] st, bit wv, bit [ID_W-1:0] id, bit lst);
			sem_result_t r;
			r.status      = st;
			r.woken_valid = wv;
			r.woken_id    = id;
			r.count_after = units;
			r.last        = lst;
			pending.push_back(r);
		endfunction

		function bit is_listed(bit [ID_W-1:0] id);
			foreach (waiters[i])
				if (waiters[i] == id)
					return 1'b1;
			return 1'b0;
		endfunction

		// work out the results that one accepted item causes
		function void note_request(bit [REQ_W-1:0] kind, bit [ID_W-1:0] id);
			bit [STAT_W-1:0] st;
			int n;
			kind_seen[kind]++;
			case (kind)
				REQ_TRY, REQ_WAIT: begin
					if (units != 0) begin
						units--;
						st = ST_GRANTED;
					end else if (kind == REQ_TRY) begin
						st = ST_REFUSED;
					end else if (waiters.size() < WAIT_CAP && !is_listed(id)) begin
						waiters.push_back(id);
						st = ST_ENQUEUED;
					end else begin
						st = ST_NOT_ENQUEUED;
						list_refusals++;
					end
					push_result(st, 1'b0, '0, 1'b1);
				end
				REQ_INC: begin
					// saturating increment, then wake the whole list oldest first
					if (units != '1)
						units++;
					n = waiters.size();
					if (n == 0) begin
						push_result(ST_INCREMENTED, 1'b0, '0, 1'b1);
					end else begin
						for (int i = 0; i < n; i++)
							push_result(ST_INCREMENTED, 1'b1, waiters[i], i == n - 1);
						woken_seen += n;
					end
					waiters.delete();
				end
				default: begin
					push_result(ST_REFUSED, 1'b0, '0, 1'b1);
				end
			endcase
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: %s", $realtime, msg);
		endfunction

		// compare one accepted result against the oldest prediction
		function void check_result(sem_result_t got);
			sem_result_t want;
			results_seen++;
			if (pending.size() == 0) begin
				flag($sformatf("result with nothing pending: status %0d id %h count %0d",
					got.status, got.woken_id, got.count_after));
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status || got.woken_valid !== want.woken_valid ||
					got.woken_id !== want.woken_id || got.count_after !== want.count_after ||
					got.last !== want.last)
				flag($sformatf({"status exp %0d got %0d, woken_valid exp %0d got %0d, ",
					"woken_id exp %h got %h, count exp %0d got %0d, last exp %0d got %0d"},
					want.status, got.status, want.woken_valid, got.woken_valid,
					want.woken_id, got.woken_id, want.count_after, got.count_after,
					want.last, got.last));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	csem_req_if req_ch();
	csem_res_if res_ch();
	csem_cfg_if cfg_ch();

	counting_semaphore_wait_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	semaphore_scoreboard sb = new();

	bit             gaps_on;
	int             hold_off;
	bit [ID_W-1:0]  id_pool[20];

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// monitors: note accepted items, configuration writes and results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.load_count(cfg_ch.initial_count);
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.req_type, req_ch.requester_id);
			if (res_ch.valid && res_ch.ready)
				sb.check_result({res_ch.status, res_ch.woken_valid, res_ch.woken_id,
					res_ch.count_after, res_ch.last});
		end
	end

	// result receiver: random stalls per item, plus one long hold-off on request
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		res_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			while (!res_ch.valid)
				@(posedge clk);
			@(negedge clk);
			stall = gaps_on ? $urandom_range(0, 3) : 0;
			if (hold_off > 0) begin
				stall = hold_off;
				hold_off = 0;
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
				res_ch.ready <= 1'b1;
			end
		end
	end

	// offer one request; returns at the falling edge after it was taken, valid still high
	task automatic send_request(bit [REQ_W-1:0] kind, bit [ID_W-1:0] id);
		int gap;
		gap = gaps_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= kind;
		req_ch.requester_id <= id;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// let every predicted result arrive, then give the block time to settle
	task automatic drain_and_settle();
		req_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_count(bit [CNT_W-1:0] value);
		cfg_ch.valid         <= 1'b1;
		cfg_ch.initial_count <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// random traffic: mostly waits on a small id pool so the list fills and repeats ids
	task automatic random_traffic(int n);
		int pick;
		bit [REQ_W-1:0] kind;
		bit [ID_W-1:0] id;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 15)
				kind = REQ_TRY;
			else if (pick < 65)
				kind = REQ_WAIT;
			else if (pick < 88)
				kind = REQ_INC;
			else
				kind = REQ_UNKNOWN;
			if ($urandom_range(0, 2) != 0)
				id = id_pool[$urandom_range(0, 19)];
			else
				id = ID_W'($urandom());
			send_request(kind, id);
		end
	endtask

	// stimulus
	initial begin
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_TRY;
		req_ch.requester_id  = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.initial_count = '0;
		gaps_on              = 1'b1;
		hold_off             = 0;
		foreach (id_pool[i])
			id_pool[i] = ID_W'($urandom());
		id_pool[0] = '0;
		id_pool[1] = '1;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty semaphore: refusal, enqueue at id extremes, duplicate, unknown code
		write_count('0);
		send_request(REQ_TRY, 31'h1234_5678);
		send_request(REQ_WAIT, '0);
		send_request(REQ_WAIT, '1);
		send_request(REQ_WAIT, '0);
		send_request(REQ_UNKNOWN, 31'h5555_5555);
		// wake both, then take the unit with a wait, then increment an empty list
		send_request(REQ_INC, 31'h2AAA_AAAA);
		send_request(REQ_WAIT, 31'h0000_0042);
		send_request(REQ_INC, '0);
		send_request(REQ_TRY, '0);

		// fill the list to capacity, one more is turned away, then wake them all
		for (int i = 0; i < WAIT_CAP; i++)
			send_request(REQ_WAIT, ID_W'(31'h0100_0000 + i));
		send_request(REQ_WAIT, 31'h0200_0000);
		send_request(REQ_INC, '0);
		drain_and_settle();

		// increment at full count stays saturated
		write_count('1);
		send_request(REQ_INC, '0);
		send_request(REQ_TRY, '1);
		drain_and_settle();

		// random phases over several counts, with and without idling
		write_count('0);
		random_traffic(20);
		drain_and_settle();

		gaps_on = 1'b0;
		write_count(CNT_W'($urandom_range(1, 4)));
		random_traffic(18);
		drain_and_settle();

		// long receiver hold-off while requests keep coming
		gaps_on = 1'b1;
		write_count('0);
		hold_off = 80;
		random_traffic(20);
		drain_and_settle();

		write_count('1);
		random_traffic(8);
		drain_and_settle();

		write_count(CNT_W'($urandom_range(0, 65535)));
		random_traffic(10);
		drain_and_settle();
		repeat (40) @(posedge clk);

		$display("run covered %0d try, %0d wait, %0d increment, %0d unknown requests",
			sb.kind_seen[REQ_TRY], sb.kind_seen[REQ_WAIT], sb.kind_seen[REQ_INC],
			sb.kind_seen[REQ_UNKNOWN]);
		$display("%0d results checked, %0d waiters woken, %0d list refusals, %0d count loads",
			sb.results_seen, sb.woken_seen, sb.list_refusals, sb.count_loads);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/csem_pkg.sv
rtl/csem_ifs.sv
rtl/csem_ram.sv
rtl/counting_semaphore_wait_queue.sv
tb/counting_semaphore_wait_queue_tb.sv
